### sv/osel_pkg.sv
// ----------------------------------------------------------------------------
// osel_pkg: shared types and codes for the order statistic selector
// Select mode and status codes, controller states, command and status groups.
// ----------------------------------------------------------------------------
package osel_pkg;

  localparam int MODE_BITS   = 3;
  localparam int STATUS_BITS = 2;

  localparam logic [MODE_BITS-1:0] MODE_MAX    = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SECOND = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_MEAN   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_FLOOR  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_LOWER  = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_TOO_FEW  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_CAND_RD,
    S_CAND_CAP,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_RESULT
  } osel_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic cand_rd;
    logic cand_cap;
    logic scan;
    logic check;
    logic finish;
  } osel_cmd_t;

  typedef struct packed {
    logic overflow;
    logic too_few;
    logic last_j;
    logic last_i;
  } osel_stat_t;

endpackage

### sv/osel_in_if.sv
// ----------------------------------------------------------------------------
// osel_in_if: sample request channel
// Valid/ready channel carrying one value of the set and its end-of-set mark.
// ----------------------------------------------------------------------------
interface osel_in_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic                         last_sample;

  modport source (output valid, output sample_value, output last_sample, input ready);
  modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

### sv/osel_out_if.sv
// ----------------------------------------------------------------------------
// osel_out_if: result request channel
// Valid/ready channel carrying the selected value, half flag and status.
// ----------------------------------------------------------------------------
interface osel_out_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] result_floor;
  logic                         result_half;
  logic [1:0]                   status_code;

  modport source (output valid, output result_floor, output result_half,
                  output status_code, input ready);
  modport sink   (input valid, input result_floor, input result_half,
                  input status_code, output ready);
endinterface

### sv/osel_ctrl.sv
// ----------------------------------------------------------------------------
// osel_ctrl: selection sequencer
// Loads the set, then walks every candidate through one rank-counting scan.
// ----------------------------------------------------------------------------
module osel_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_last,
  output logic               sample_ready,
  output logic               result_valid,
  input  logic               result_ready,
  input  osel_pkg::osel_stat_t stat,
  output osel_pkg::osel_cmd_t  cmd
);
  import osel_pkg::*;

  osel_state_t state, state_next;
  logic        result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    cmd               = '0;
    state_next        = state;
    sample_ready      = (state == S_LOAD);
    result_valid_next = result_ready ? 1'b0 : result_valid;
    case (state)
      S_LOAD: begin
        if (sample_valid) begin
          cmd.load = 1'b1;
          if (sample_last) state_next = S_START;
        end
      end
      S_START: begin
        if (stat.overflow || stat.too_few) begin
          state_next = S_RESULT;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_CAND_RD;
        end
      end
      S_CAND_RD: begin
        cmd.cand_rd = 1'b1;
        state_next  = S_CAND_CAP;
      end
      S_CAND_CAP: begin
        cmd.cand_cap = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_j) state_next = S_DRAIN;
      end
      // last compare lands at the end of this cycle
      S_DRAIN: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = stat.last_i ? S_RESULT : S_CAND_RD;
      end
      S_RESULT: begin
        if (!result_valid || result_ready) begin
          cmd.finish        = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

### sv/osel_dp.sv
// ----------------------------------------------------------------------------
// osel_dp: selection datapath
// Value store, rank counter with one shared comparator, result register.
// ----------------------------------------------------------------------------
module osel_dp #(
  parameter int MAX_VALUES = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  osel_pkg::osel_cmd_t               cmd,
  output osel_pkg::osel_stat_t              stat,
  input  logic                              cfg_we,
  input  logic [osel_pkg::MODE_BITS-1:0]    cfg_wdata,
  input  logic signed [VALUE_BITS-1:0]      sample_value,
  output logic signed [VALUE_BITS-1:0]      result_floor,
  output logic                              result_half,
  output logic [osel_pkg::STATUS_BITS-1:0]  status_code
);
  import osel_pkg::*;

  localparam int AW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int CW = $clog2(MAX_VALUES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_VALUES);

  logic [MODE_BITS-1:0]         select_mode;
  logic [CW-1:0]                count;
  logic                         overflow;
  logic signed [VALUE_BITS-1:0] mem [MAX_VALUES];
  logic signed [VALUE_BITS-1:0] rdata;
  logic [AW-1:0]                rd_addr;
  logic [AW-1:0]                i, j, pipe_idx;
  logic                         pipe_v;
  logic signed [VALUE_BITS-1:0] cand, a, b;
  logic [CW-1:0]                rank, ta, tb, ta_next, tb_next;
  logic                         half_en, half_en_next;
  logic [CW-1:0]                half_n;
  logic signed [VALUE_BITS:0]   sum;
  logic                         full;
  logic                         lower;

  assign full    = (count == FULL);
  assign rd_addr = cmd.cand_rd ? i : j;
  assign half_n  = count >> 1;
  assign sum     = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
  // stable rank: ties broken by store position
  assign lower   = (rdata < cand) || ((rdata == cand) && (pipe_idx < i));

  assign stat.overflow = overflow;
  assign stat.too_few  = (select_mode == MODE_SECOND) && (count < CW'(2));
  assign stat.last_j   = (CW'(j) == count - CW'(1));
  assign stat.last_i   = (CW'(i) == count - CW'(1));

  // sorted positions wanted; tb differs from ta only for an even count in the floor or mean (default) modes
  always_comb begin
    ta_next      = count - CW'(1);
    tb_next      = count - CW'(1);
    half_en_next = 1'b0;
    case (select_mode)
      MODE_MAX: begin
        ta_next = count - CW'(1);
        tb_next = ta_next;
      end
      MODE_SECOND: begin
        ta_next = count - CW'(2);
        tb_next = ta_next;
      end
      MODE_LOWER: begin
        ta_next = count[0] ? half_n : half_n - CW'(1);
        tb_next = ta_next;
      end
      MODE_FLOOR: begin
        ta_next = count[0] ? half_n : half_n - CW'(1);
        tb_next = half_n;
      end
      default: begin
        ta_next      = count[0] ? half_n : half_n - CW'(1);
        tb_next      = half_n;
        half_en_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode <= MODE_MEAN;
      count       <= '0;
      overflow    <= 1'b0;
      pipe_v      <= 1'b0;
    end else begin
      if (cfg_we) select_mode <= cfg_wdata;
      if (cmd.load) begin
        if (!full) count <= count + CW'(1);
        else       overflow <= 1'b1;
      end
      if (cmd.finish) begin
        count    <= '0;
        overflow <= 1'b0;
      end
      pipe_v <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) mem[count[AW-1:0]] <= sample_value;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    pipe_idx <= j;
    if (cmd.start) begin
      i       <= '0;
      j       <= '0;
      rank    <= '0;
      ta      <= ta_next;
      tb      <= tb_next;
      half_en <= half_en_next;
    end
    if (cmd.cand_cap) cand <= rdata;
    if (cmd.scan) j <= j + AW'(1);
    if (pipe_v && lower) rank <= rank + CW'(1);
    if (cmd.check) begin
      if (rank == ta) a <= cand;
      if (rank == tb) b <= cand;
      rank <= '0;
      j    <= '0;
      i    <= i + AW'(1);
    end
    if (cmd.finish) begin
      if (overflow) begin
        result_floor <= '0;
        result_half  <= 1'b0;
        status_code  <= STATUS_OVERFLOW;
      end else if (stat.too_few) begin
        result_floor <= '0;
        result_half  <= 1'b0;
        status_code  <= STATUS_TOO_FEW;
      end else begin
        // floor of the mean; a single pick has a == b so this gives it back
        result_floor <= sum[VALUE_BITS:1];
        result_half  <= sum[0] & half_en;
        status_code  <= STATUS_OK;
      end
    end
  end

endmodule

### sv/order_statistic_selector.sv
// A set that overflowed or is too small for the mode skips the scan and goes
//   straight to the result.
// Throughput: one value per cycle while loading; no new set loads until the result
//   is issued; the single store read port feeds one shared comparator.
// Reset: control cleared, select_mode = 2 (median mean); store contents undefined.
// ----------------------------------------------------------------------------
// order_statistic_selector: max, second largest or median of a loaded set
// Rank-counting selection over a value store, with a registered result.
// ----------------------------------------------------------------------------
module order_statistic_selector #(
  parameter int MAX_VALUES = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [osel_pkg::MODE_BITS-1:0] cfg_wdata,
  osel_in_if.sink                        samples,
  osel_out_if.source                     results
);
  import osel_pkg::*;

  osel_cmd_t  cmd;
  osel_stat_t stat;

  osel_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (samples.valid),
    .sample_last  (samples.last_sample),
    .sample_ready (samples.ready),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  osel_dp #(
    .MAX_VALUES (MAX_VALUES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .sample_value (samples.sample_value),
    .result_floor (results.result_floor),
    .result_half  (results.result_half),
    .status_code  (results.status_code)
  );

endmodule
